FILE: src/mlp_pkg.sv
// Package: weights, biases, sigmoid table and shared types for the perceptron.
`default_nettype none
package mlp_pkg;
  localparam int NIn  = 6;
  localparam int NHid = 4;
  localparam int NOut = 3;
  localparam int AccW = 40;

  typedef logic signed [15:0] w_t;
  typedef logic signed [AccW-1:0] acc_t;

  function automatic w_t w_hid(input int i, input int j);
    w_t t [0:5][0:3];
    t[0] = '{16'sd12408, -16'sd6561, -16'sd1484, -16'sd10099};
    t[1] = '{16'sd1689, -16'sd2068, -16'sd3138, -16'sd5588};
    t[2] = '{16'sd7419, -16'sd643, -16'sd2043, 16'sd110};
    t[3] = '{16'sd21228, -16'sd5512, -16'sd11514, -16'sd7218};
    t[4] = '{16'sd17922, -16'sd8046, -16'sd567, -16'sd6168};
    t[5] = '{16'sd13592, -16'sd6950, -16'sd510, -16'sd4235};
    return t[i][j];
  endfunction

  function automatic w_t b_hid(input int j);
    w_t t [0:3];
    t = '{16'sd9467, -16'sd878, 16'sd4909, 16'sd2159};
    return t[j];
  endfunction

  function automatic w_t w_out(input int j, input int k);
    w_t t [0:3][0:2];
    t[0] = '{16'sd12021, 16'sd4938, -16'sd17799};
    t[1] = '{16'sd18474, -16'sd28674, 16'sd3722};
    t[2] = '{-16'sd9818, 16'sd1532, 16'sd22303};
    t[3] = '{-16'sd18106, 16'sd31813, -16'sd14282};
    return t[j][k];
  endfunction

  function automatic w_t b_out(input int k);
    w_t t [0:2];
    t = '{-16'sd3289, -16'sd9393, -16'sd2389};
    return t[k];
  endfunction

  function automatic logic [15:0] sig_tab(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0: r = 16'd32768;  5'd1: r = 16'd40793;  5'd2: r = 16'd47911;
      5'd3: r = 16'd53581;  5'd4: r = 16'd57724;  5'd5: r = 16'd60565;
      5'd6: r = 16'd62428;  5'd7: r = 16'd63615;  5'd8: r = 16'd64357;
      5'd9: r = 16'd64816;  5'd10: r = 16'd65097; 5'd11: r = 16'd65269;
      5'd12: r = 16'd65374; 5'd13: r = 16'd65438; 5'd14: r = 16'd65476;
      5'd15: r = 16'd65500; default: r = 16'd65514;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/mlp_mac_cell.sv
// One multiply-accumulate cell: adds weight times operand to a passing partial sum.
`default_nettype none
module mlp_mac_cell (
  input  wire logic                      clk,
  input  wire logic signed [16:0]        x,
  input  wire logic signed [15:0]        w,
  input  wire mlp_pkg::acc_t             acc,
  output mlp_pkg::acc_t                  acc_q
);
  logic signed [32:0] prod;
  assign prod = x * w;
  always_ff @(posedge clk) begin
    acc_q <= acc + mlp_pkg::acc_t'(prod);
  end
endmodule
`default_nettype wire

FILE: src/mlp_sigmoid.sv
// Pipelined sigmoid: round the net input, then interpolate the table.
`default_nettype none
module mlp_sigmoid #(
  parameter int Drop = 10
) (
  input  wire logic          clk,
  input  wire mlp_pkg::acc_t net,
  output logic [15:0]        y
);
  mlp_pkg::acc_t r;
  logic        sat_hi, sat_lo, neg;
  logic [15:0] a;
  logic [15:0] base;
  logic [16:0] dif;
  logic [27:0] prod;
  logic        sat_hi_q, sat_lo_q, neg_q;
  logic [15:0] base_q;
  logic [16:0] s;

  assign r = (net + (mlp_pkg::acc_t'(1) <<< (Drop - 1))) >>> Drop;
  always_ff @(posedge clk) begin
    sat_hi <= r >= 32768;
    sat_lo <= r < -32768;
    neg    <= r[mlp_pkg::AccW-1];
    a      <= r[mlp_pkg::AccW-1] ? 16'(-r) : 16'(r);
  end
  assign base = mlp_pkg::sig_tab(a[15:11]);
  assign dif  = 17'(mlp_pkg::sig_tab(5'(a[15:11]) + 5'd1)) - 17'(base);
  always_ff @(posedge clk) begin
    base_q <= base;
    prod <= a[15] ? 28'd0 : 28'(dif) * 28'(a[10:0]);
    sat_hi_q <= sat_hi; sat_lo_q <= sat_lo; neg_q <= neg;
  end
  assign s = 17'(base_q) + 17'((prod + 28'd1024) >> 11);
  always_ff @(posedge clk) begin
    if (sat_hi_q) y <= 16'hFFFF;
    else if (sat_lo_q) y <= 16'd0;
    else if (neg_q) y <= 16'(17'h10000 - s);
    else y <= (s[16]) ? 16'hFFFF : s[15:0];
  end
endmodule
`default_nettype wire

FILE: src/mlp_classifier_6_4_3.sv
// Top level of the 6-4-3 sigmoid perceptron built as chains of MAC cells.
//
// One feature vector is accepted per cycle (busy never rises). Each neuron
// is a chain of multiply-accumulate cells, one cell per input, and the
// partial sum advances one cell per clock while skewed operand delay lines
// hold each input until its cell is reached. Each item passes through the
// hidden chains, their sigmoids, the output chains and the output sigmoids
// in that order; its result beat on done cannot be held off by the
// receiver. The block keeps no state between items.
`default_nettype none
module mlp_classifier_6_4_3 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] feature_0,
  input  wire logic signed [15:0] feature_1,
  input  wire logic signed [15:0] feature_2,
  input  wire logic signed [15:0] feature_3,
  input  wire logic signed [15:0] feature_4,
  input  wire logic signed [15:0] feature_5,
  output logic                    done,
  output logic [15:0]             class_score_0,
  output logic [15:0]             class_score_1,
  output logic [15:0]             class_score_2
);
  localparam int NIn = mlp_pkg::NIn;
  localparam int NHid = mlp_pkg::NHid;
  localparam int NOut = mlp_pkg::NOut;
  localparam int Lat = NIn + 3 + NHid + 3;

  logic signed [15:0] feat [NIn];
  assign feat = '{feature_0, feature_1, feature_2, feature_3, feature_4, feature_5};
  assign busy = 1'b0;

  // skewed delay lines: each input is delayed in step with the partial sum before it reaches its cell
  logic signed [15:0] xd [NIn][NIn];
  always_ff @(posedge clk) begin
    for (int i = 0; i < NIn; i++) begin
      xd[i][0] <= feat[i];
      for (int d = 1; d < NIn; d++) xd[i][d] <= xd[i][d-1];
    end
  end

  mlp_pkg::acc_t hacc [NHid][NIn+1];
  logic [15:0] h [NHid];
  for (genvar j = 0; j < NHid; j++) begin : g_hid
    assign hacc[j][0] = mlp_pkg::acc_t'(mlp_pkg::b_hid(j)) <<< 12;
    for (genvar i = 0; i < NIn; i++) begin : g_cell
      logic signed [16:0] xin;
      assign xin = (i == 0) ? 17'(feat[0]) : 17'(xd[i][(i == 0) ? 0 : i-1]);
      mlp_mac_cell u_cell (.clk, .x(xin), .w(mlp_pkg::w_hid(i, j)),
                           .acc(hacc[j][i]), .acc_q(hacc[j][i+1]));
    end
    mlp_sigmoid #(.Drop(10)) u_sig (.clk, .net(hacc[j][NIn]), .y(h[j]));
  end

  logic [15:0] hd [NHid][NHid];
  always_ff @(posedge clk) begin
    for (int j = 0; j < NHid; j++) begin
      hd[j][0] <= h[j];
      for (int d = 1; d < NHid; d++) hd[j][d] <= hd[j][d-1];
    end
  end

  mlp_pkg::acc_t oacc [NOut][NHid+1];
  for (genvar k = 0; k < NOut; k++) begin : g_out
    assign oacc[k][0] = mlp_pkg::acc_t'(mlp_pkg::b_out(k)) <<< 16;
    for (genvar j = 0; j < NHid; j++) begin : g_cell
      logic signed [16:0] hin;
      assign hin = (j == 0) ? {1'b0, h[0]} : {1'b0, hd[j][(j == 0) ? 0 : j-1]};
      mlp_mac_cell u_cell (.clk, .x(hin), .w(mlp_pkg::w_out(j, k)),
                           .acc(oacc[k][j]), .acc_q(oacc[k][j+1]));
    end
  end
  mlp_sigmoid #(.Drop(14)) u_s0 (.clk, .net(oacc[0][NHid]), .y(class_score_0));
  mlp_sigmoid #(.Drop(14)) u_s1 (.clk, .net(oacc[1][NHid]), .y(class_score_1));
  mlp_sigmoid #(.Drop(14)) u_s2 (.clk, .net(oacc[2][NHid]), .y(class_score_2));

  // valid tokens advance alongside the data
  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], start};
  end
  assign done = vld[Lat-1];

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##Lat (done || $past(rst, Lat))) else $error("result beat missing");
  a_nob: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({class_score_0, class_score_1, class_score_2}))
    else $error("unknown class score on result beat");
`endif
endmodule
`default_nettype wire
